>>> rtl/core/circular_array_indexed_insert_remove_assert.svh
// Assertion macros shared by the RTL files. Each expects clk and rst_n in scope.
`ifndef CIRCULAR_ARRAY_INDEXED_INSERT_REMOVE_ASSERT_SVH
`define CIRCULAR_ARRAY_INDEXED_INSERT_REMOVE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CAIR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cair assertion failed");
`define CAIR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cair assertion failed");
`else
`define CAIR_ASSERT_IMP(label, ante, cons)
`define CAIR_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> rtl/core/cair_pkg.sv
`timescale 1ns / 1ps

package cair_pkg;

    localparam int IDX_W   = 6;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        ACT_GET,
        ACT_SET,
        ACT_INS,
        ACT_REM
    } action_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_RANGE,
        ST_FULL,
        ST_EMPTY
    } status_t;

    typedef struct packed {
        logic load;
        logic plan;
        logic fetch;
        logic capture;
        logic step;
        logic commit;
    } cair_cmd_t;

    typedef struct packed {
        logic ok;
        logic moves_done;
    } cair_sts_t;

endpackage

>>> rtl/core/cair_ctrl.sv
`timescale 1ns / 1ps
`include "circular_array_indexed_insert_remove_assert.svh"

module cair_ctrl
    import cair_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output cair_cmd_t cmd,
    input  cair_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_CAPTURE,
        S_MOVE,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.plan   = 1'b1;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                if (sts.ok)
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_CAPTURE;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_CAPTURE:
            begin
                cmd.capture = 1'b1;
                state_next  = S_MOVE;
            end
            S_MOVE:
            begin
                if (sts.moves_done)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `CAIR_ASSERT_NXT(a_accept_decode, in_valid && in_ready, state_reg == S_DECODE)
    `CAIR_ASSERT_IMP(a_commit_free, cmd.commit, !out_valid_reg || out_ready)
    `CAIR_ASSERT_IMP(a_step_ok, cmd.step, sts.ok)
    `CAIR_ASSERT_NXT(a_commit_valid, cmd.commit, out_valid_reg)

endmodule

>>> rtl/core/cair_dp.sv
`timescale 1ns / 1ps
`include "circular_array_indexed_insert_remove_assert.svh"

module cair_dp
    import cair_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cair_cmd_t          cmd,
    output cair_sts_t          sts,
    input  logic [1:0]         action,
    input  logic [IDX_W-1:0]   logical_index,
    input  logic [VALUE_W-1:0] entry_value,
    output logic [VALUE_W-1:0] read_value,
    output logic [1:0]         status,
    output logic [COUNT_W-1:0] count_after
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > IDX_W - 1) ? CW : IDX_W - 1;
    localparam int SW = EW + 1;

    function automatic logic [PW-1:0] slot_add(input logic [PW-1:0] base,
                                               input logic [EW-1:0] ofs);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(ofs);
        if (s >= SW'(DEPTH))
        begin
            s = s - SW'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
    endfunction

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    action_t               act_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [DATA_WIDTH-1:0] val_reg;

    logic [PW-1:0]         head_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         left_reg;
    logic                  pend_reg;
    logic [PW-1:0]         rp_reg;
    logic [PW-1:0]         wp_reg;
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [DATA_WIDTH-1:0] rv_reg;

    status_t               st_reg;
    logic                  rd_reg;
    logic [PW-1:0]         tgt_reg;
    logic                  fin_we_reg;
    logic [PW-1:0]         fin_reg;
    logic                  up_reg;
    logic [PW-1:0]         head_new_reg;
    logic [CW-1:0]         cnt_new_reg;

    logic [VALUE_W-1:0]    read_value_reg;
    status_t               status_reg;
    logic [COUNT_W-1:0]    count_after_reg;

    // plan decode
    status_t       p_st;
    logic          p_rd;
    logic [PW-1:0] p_tgt;
    logic          p_fin_we;
    logic [PW-1:0] p_fin;
    logic [CW-1:0] p_n;
    logic [PW-1:0] p_rp;
    logic [PW-1:0] p_wp;
    logic          p_up;
    logic [PW-1:0] p_head;
    logic [CW-1:0] p_cnt;

    logic          neg;
    logic [EW-1:0] ix;
    logic [EW-1:0] cn;
    logic [EW-1:0] half;
    logic          is_m1;
    logic          in_rng;
    logic          eq_cnt;
    logic          le_cnt;
    logic          full;
    logic          empty;
    logic [PW-1:0] head_m1;
    logic [PW-1:0] head_p1;

    always_comb
    begin
        neg     = idx_reg[IDX_W-1];
        ix      = EW'(idx_reg[IDX_W-2:0]);
        cn      = EW'(count_reg);
        half    = cn >> 1;
        is_m1   = (idx_reg == '1);
        in_rng  = !neg && (ix < cn);
        eq_cnt  = !neg && (ix == cn);
        le_cnt  = !neg && (ix <= cn);
        full    = (count_reg == CW'(DEPTH));
        empty   = (count_reg == '0);
        head_m1 = ptr_dec(head_reg);
        head_p1 = ptr_inc(head_reg);

        p_st     = ST_OK;
        p_rd     = 1'b0;
        p_tgt    = slot_add(head_reg, ix);
        p_fin_we = 1'b0;
        p_fin    = p_tgt;
        p_n      = '0;
        p_rp     = head_reg;
        p_wp     = head_reg;
        p_up     = 1'b1;
        p_head   = head_reg;
        p_cnt    = count_reg;

        case (act_reg)
            ACT_GET:
            begin
                if (empty)
                begin
                    p_st = ST_EMPTY;
                end
                else if (!in_rng)
                begin
                    p_st = ST_RANGE;
                end
                else
                begin
                    p_rd = 1'b1;
                end
            end
            ACT_SET:
            begin
                if (eq_cnt)
                begin
                    if (full)
                    begin
                        p_st = ST_FULL;
                    end
                    else
                    begin
                        p_fin_we = 1'b1;
                        p_fin    = slot_add(head_reg, cn);
                        p_cnt    = count_reg + CW'(1);
                    end
                end
                else if (is_m1)
                begin
                    if (full)
                    begin
                        p_st = ST_FULL;
                    end
                    else
                    begin
                        p_fin_we = 1'b1;
                        p_fin    = head_m1;
                        p_head   = head_m1;
                        p_cnt    = count_reg + CW'(1);
                    end
                end
                else if (in_rng)
                begin
                    p_rd     = 1'b1;
                    p_fin_we = 1'b1;
                end
                else
                begin
                    p_st = ST_RANGE;
                end
            end
            ACT_INS:
            begin
                if (!le_cnt)
                begin
                    p_st = ST_RANGE;
                end
                else if (full)
                begin
                    p_st = ST_FULL;
                end
                else
                begin
                    p_fin_we = 1'b1;
                    p_cnt    = count_reg + CW'(1);
                    if (ix == cn || ix > half)
                    begin
                        // tail side moves up by one
                        p_n  = CW'(cn - ix);
                        p_rp = slot_add(head_m1, cn);
                        p_wp = slot_add(head_reg, cn);
                        p_up = 1'b0;
                    end
                    else
                    begin
                        // head side moves down by one
                        p_n    = CW'(ix);
                        p_rp   = head_reg;
                        p_wp   = head_m1;
                        p_up   = 1'b1;
                        p_fin  = slot_add(head_m1, ix);
                        p_head = head_m1;
                    end
                end
            end
            ACT_REM:
            begin
                if (empty)
                begin
                    p_st = ST_EMPTY;
                end
                else if (!in_rng)
                begin
                    p_st = ST_RANGE;
                end
                else
                begin
                    p_rd  = 1'b1;
                    p_cnt = count_reg - CW'(1);
                    if (ix == cn - EW'(1) || ix > half)
                    begin
                        p_n  = CW'(cn - ix - EW'(1));
                        p_rp = slot_add(head_p1, ix);
                        p_wp = p_tgt;
                        p_up = 1'b1;
                    end
                    else
                    begin
                        p_n    = CW'(ix);
                        p_rp   = slot_add(head_m1, ix);
                        p_wp   = p_tgt;
                        p_up   = 1'b0;
                        p_head = head_p1;
                    end
                end
            end
            default:
            begin
                p_st = ST_OK;
            end
        endcase
    end

    // memory port control
    logic                  mem_we;
    logic [PW-1:0]         mem_wa;
    logic [DATA_WIDTH-1:0] mem_wd;
    logic                  mem_re;
    logic [PW-1:0]         mem_ra;
    logic                  step_rd;

    always_comb
    begin
        step_rd = cmd.step && (left_reg != '0);
        mem_we  = 1'b0;
        mem_wa  = wp_reg;
        mem_wd  = rdata_reg;
        if (cmd.step && pend_reg)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.commit && fin_we_reg)
        begin
            mem_we = 1'b1;
            mem_wa = fin_reg;
            mem_wd = val_reg;
        end
        mem_re = step_rd || (cmd.fetch && rd_reg);
        mem_ra = step_rd ? rp_reg : tgt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.plan)
            begin
                left_reg <= p_n;
                pend_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                pend_reg <= step_rd;
                if (step_rd)
                begin
                    left_reg <= left_reg - CW'(1);
                end
            end
            if (cmd.commit)
            begin
                head_reg  <= head_new_reg;
                count_reg <= cnt_new_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action_t'(action);
            idx_reg <= logical_index;
            val_reg <= DATA_WIDTH'(entry_value);
        end
        if (cmd.plan)
        begin
            st_reg       <= p_st;
            rd_reg       <= p_rd;
            tgt_reg      <= p_tgt;
            fin_we_reg   <= p_fin_we;
            fin_reg      <= p_fin;
            up_reg       <= p_up;
            head_new_reg <= p_head;
            cnt_new_reg  <= p_cnt;
            rp_reg       <= p_rp;
            wp_reg       <= p_wp;
        end
        else if (cmd.step)
        begin
            if (step_rd)
            begin
                rp_reg <= up_reg ? ptr_inc(rp_reg) : ptr_dec(rp_reg);
            end
            if (pend_reg)
            begin
                wp_reg <= up_reg ? ptr_inc(wp_reg) : ptr_dec(wp_reg);
            end
        end
        if (cmd.capture && rd_reg)
        begin
            rv_reg <= rdata_reg;
        end
        if (cmd.commit)
        begin
            read_value_reg  <= (st_reg == ST_OK && rd_reg) ? VALUE_W'(rv_reg) : '0;
            status_reg      <= st_reg;
            count_after_reg <= COUNT_W'(cnt_new_reg);
        end
    end

    assign sts.ok         = (st_reg == ST_OK);
    assign sts.moves_done = (left_reg == '0) && !pend_reg;

    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign count_after = count_after_reg;

    `CAIR_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `CAIR_ASSERT_IMP(a_head_bound, 1'b1, head_reg <= PW'(DEPTH - 1))
    `CAIR_ASSERT_IMP(a_commit_drained, cmd.commit, left_reg == '0 && !pend_reg)

endmodule

>>> rtl/core/circular_array_indexed_insert_remove.sv
`timescale 1ns / 1ps
// Channel  | Signals                                        | Direction
// input    | in_valid, in_ready, action, logical_index,     | in
//          | entry_value                                    |
// output   | out_valid, out_ready, read_value, status,      | out
//          | count_after                                    |
//
// A transaction runs decode, fetch, capture, move and commit; an error status goes
// from fetch to commit. End inserts and removes shift no entries, inner ones at most
// count/2, through the single read and single write port of the entry memory, one entry
// per cycle. Reset clears head, count and the shift and control state; memory contents
// are not cleared. A finished result waits in the output register; the next transaction
// is accepted meanwhile, and its commit waits until that result is taken.

module circular_array_indexed_insert_remove
    import cair_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [IDX_W-1:0]   logical_index,
    input  logic [VALUE_W-1:0] entry_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] read_value,
    output logic [1:0]         status,
    output logic [COUNT_W-1:0] count_after
);

    cair_cmd_t cmd;
    cair_sts_t sts;

    cair_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    cair_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .action        (action),
        .logical_index (logical_index),
        .entry_value   (entry_value),
        .read_value    (read_value),
        .status        (status),
        .count_after   (count_after)
    );

endmodule
